>>> hw/rtl/i32alu_pkg.sv
// Shared types and codes for the 32-bit scalar ALU.
// No dependencies.
`default_nettype none
package i32alu_pkg;
    localparam int DEF_WORD_BITS = 32;
    localparam int OP_BITS       = 5;
    localparam int FIELD_BITS    = 32;

    typedef enum logic [4:0] {
        OP_ADD = 5'd0,  OP_SUB = 5'd1,  OP_MUL = 5'd2,  OP_DIV = 5'd3,
        OP_MOD = 5'd4,  OP_AND = 5'd5,  OP_OR  = 5'd6,  OP_XOR = 5'd7,
        OP_SHL = 5'd8,  OP_SHR = 5'd9,  OP_MAX = 5'd10, OP_MIN = 5'd11,
        OP_NEG = 5'd12, OP_ABS = 5'd13, OP_NOT = 5'd14, OP_EQ  = 5'd15,
        OP_NE  = 5'd16, OP_LT  = 5'd17, OP_LE  = 5'd18, OP_GT  = 5'd19,
        OP_GE  = 5'd20, OP_SEL = 5'd21
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DIV0  = 2'd1,
        ST_OVF   = 2'd2,
        ST_SHIFT = 2'd3
    } status_t;
endpackage
`default_nettype wire

>>> hw/rtl/int32_scalar_alu.sv
// Top level of the 32-bit scalar ALU with a pipelined divider.
// Depends on i32alu_pkg and i32alu_div.
`default_nettype none
// Usage:
//   Requests arrive as beats on the s_axis channel; results leave as beats
//   on m_axis, one per request, in request order.
//   s_axis_tdata: req_type[4:0], is_signed[5], operand_a[37:6],
//   operand_b[69:38], operand_c[101:70], zero fill to 104 bits.
//   m_axis_tdata: result_word[31:0], status[33:32], zero fill to 40 bits.
// Pipeline:
//   Stage 1 registers the request and takes operand magnitudes; then
//   WORD_BITS divider stages (one quotient bit each); then a fix-up stage
//   applies signs, and a final stage selects the result. Every operation
//   walks the same path, and the block takes one beat per cycle while the
//   output is not stalled.
// Stall:
//   The whole pipe advances as one when the output register is empty or is
//   being drained; a held m_axis beat freezes every stage, dropping nothing.
// Reset:
//   rst_n clears all valid bits; payload registers are not reset.
module int32_scalar_alu
    import i32alu_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [103:0] s_axis_tdata,  // req_type, is_signed, a, b, c
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [39:0]       m_axis_tdata   // result_word, status
);
    localparam int W    = WORD_BITS;
    localparam int LAT  = W + 3;
    localparam int TAGW = 3;  // sign of quotient, sign of remainder, sign of divisor

    // advance the whole pipe when the output slot frees up
    logic adv;
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    logic [4:0]            in_op;
    logic                  in_sgn;
    logic [FIELD_BITS-1:0] in_a, in_b, in_c;
    assign in_op  = s_axis_tdata[4:0];
    assign in_sgn = s_axis_tdata[5];
    assign in_a   = s_axis_tdata[37:6];
    assign in_b   = s_axis_tdata[69:38];
    assign in_c   = s_axis_tdata[101:70];

    // valid line, one bit per stage
    logic [LAT-1:0] vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
    end
    assign m_axis_tvalid = vld_reg[LAT-1];

    // stage 1: capture operands
    logic [4:0]   op_reg;
    logic         sgn_reg;
    logic [W-1:0] a_reg, b_reg, c_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op_reg  <= in_op;
            sgn_reg <= in_sgn;
            a_reg   <= W'(in_a);
            b_reg   <= W'(in_b);
            c_reg   <= W'(in_c);
        end
    end

    // simple ops evaluated from stage 1, then delayed alongside the divider
    logic [W-1:0] mag_a, mag_b, simple_r;
    logic [1:0]   simple_st;
    logic         na, nb, lt_ab, lt_ba;
    logic [W-1:0] sb;
    assign sb    = {1'b1, {(W-1){1'b0}}};
    assign na    = a_reg[W-1];
    assign nb    = b_reg[W-1];
    assign mag_a = (sgn_reg && na) ? W'(-a_reg) : a_reg;
    assign mag_b = (sgn_reg && nb) ? W'(-b_reg) : b_reg;
    assign lt_ab = sgn_reg ? ((a_reg ^ sb) < (b_reg ^ sb)) : (a_reg < b_reg);
    assign lt_ba = sgn_reg ? ((b_reg ^ sb) < (a_reg ^ sb)) : (b_reg < a_reg);

    logic [2*W-1:0] prod;
    assign prod = a_reg * b_reg;

    always_comb
    begin
        simple_r  = '0;
        simple_st = ST_OK;
        case (op_reg)
            OP_ADD: simple_r = a_reg + b_reg;
            OP_SUB: simple_r = a_reg - b_reg;
            OP_MUL: simple_r = prod[W-1:0];
            OP_DIV, OP_MOD:
            begin
                if (b_reg == '0)
                    simple_st = ST_DIV0;
                else if (sgn_reg && a_reg == sb && b_reg == '1)
                    simple_st = ST_OVF;
            end
            OP_AND: simple_r = a_reg & b_reg;
            OP_OR:  simple_r = a_reg | b_reg;
            OP_XOR: simple_r = a_reg ^ b_reg;
            OP_SHL, OP_SHR:
            begin
                if (b_reg >= W'(W))
                    simple_st = ST_SHIFT;
                else if (op_reg == OP_SHL)
                    simple_r = a_reg << b_reg;
                else if (sgn_reg)
                    simple_r = W'($signed(a_reg) >>> b_reg);
                else
                    simple_r = a_reg >> b_reg;
            end
            OP_MAX: simple_r = lt_ba ? a_reg : b_reg;
            OP_MIN: simple_r = lt_ab ? a_reg : b_reg;
            OP_NEG: simple_r = W'(-a_reg);
            OP_ABS: simple_r = na ? W'(-a_reg) : a_reg;
            OP_NOT: simple_r = ~a_reg;
            OP_EQ:  simple_r = W'(a_reg == b_reg);
            OP_NE:  simple_r = W'(a_reg != b_reg);
            OP_LT:  simple_r = W'(lt_ab);
            OP_LE:  simple_r = W'(!lt_ba);
            OP_GT:  simple_r = W'(lt_ba);
            OP_GE:  simple_r = W'(!lt_ab);
            OP_SEL: simple_r = (a_reg != '0) ? b_reg : c_reg;
            default: simple_r = '0;
        endcase
    end

    // divider sees magnitudes; divide by zero is masked later
    logic [TAGW-1:0] dtag_in, dtag_out;
    logic [W-1:0]    quo, rem;
    assign dtag_in = {sgn_reg && nb, sgn_reg && na, sgn_reg && (na ^ nb)};

    i32alu_div #(.W(W), .TAGW(TAGW)) u_div (
        .clk      (clk),
        .en       (adv),
        .dividend (mag_a),
        .divisor  (mag_b),
        .tag_in   (dtag_in),
        .quotient (quo),
        .remainder(rem),
        .tag_out  (dtag_out)
    );

    // delay line for op, b, simple result, status
    logic [4:0]   op_d_reg  [W];
    logic [W-1:0] b_d_reg   [W];
    logic [W-1:0] sr_d_reg  [W];
    logic [1:0]   st_d_reg  [W];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op_d_reg[0] <= op_reg;
            b_d_reg[0]  <= b_reg;
            sr_d_reg[0] <= simple_r;
            st_d_reg[0] <= simple_st;
            for (int i = 1; i < W; i++)
            begin
                op_d_reg[i] <= op_d_reg[i-1];
                b_d_reg[i]  <= b_d_reg[i-1];
                sr_d_reg[i] <= sr_d_reg[i-1];
                st_d_reg[i] <= st_d_reg[i-1];
            end
        end
    end

    // fix-up stage: apply signs
    logic [W-1:0] q_fix_reg, r_fix_reg, sr_f_reg, b_f_reg;
    logic [4:0]   op_f_reg;
    logic [1:0]   st_f_reg;
    logic         rneg_f_reg, bneg_f_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_fix_reg  <= dtag_out[0] ? W'(-quo) : quo;
            r_fix_reg  <= dtag_out[1] ? W'(-rem) : rem;
            rneg_f_reg <= dtag_out[1];
            bneg_f_reg <= dtag_out[2];
            sr_f_reg   <= sr_d_reg[W-1];
            b_f_reg    <= b_d_reg[W-1];
            op_f_reg   <= op_d_reg[W-1];
            st_f_reg   <= st_d_reg[W-1];
        end
    end

    // final stage: modulo sign correction (signed only) and result select
    logic [W-1:0] mod_r, fin_r;
    always_comb
    begin
        mod_r = r_fix_reg;
        if (r_fix_reg != '0 && (r_fix_reg[W-1] != b_f_reg[W-1]))
            mod_r = r_fix_reg + b_f_reg;
        if (st_f_reg != ST_OK)
            fin_r = '0;
        else if (op_f_reg == OP_DIV)
            fin_r = q_fix_reg;
        else if (op_f_reg == OP_MOD)
            fin_r = (rneg_f_reg || bneg_f_reg) ? mod_r : r_fix_reg;
        else
            fin_r = sr_f_reg;
    end

    logic [W-1:0] res_reg;
    logic [1:0]   sto_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= fin_r;
            sto_reg <= st_f_reg;
        end
    end

    logic [FIELD_BITS-1:0] res_out;
    if (W >= FIELD_BITS) begin : g_wide
        assign res_out = res_reg[FIELD_BITS-1:0];
    end else begin : g_narrow
        assign res_out = FIELD_BITS'(res_reg);
    end
    assign m_axis_tdata = {6'd0, sto_reg, res_out};

    // a stalled output beat keeps the pipe frozen
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(vld_reg))
        else $error("pipe moved under stall");
    // an error status always carries a zero word
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && sto_reg != ST_OK |-> res_reg == '0)
        else $error("error with nonzero result");
    // ready follows the output slot
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("not ready with empty output");
endmodule
`default_nettype wire

>>> hw/rtl/i32alu_div.sv
// Pipelined unsigned restoring divider: one quotient bit per stage.
// Depends on i32alu_pkg. Carries a tag alongside each item; advances when en.
`default_nettype none
module i32alu_div
    import i32alu_pkg::*;
#(
    parameter int W    = DEF_WORD_BITS,
    parameter int TAGW = 8
)
(
    input  wire logic            clk,
    input  wire logic            en,
    input  wire logic [W-1:0]    dividend,
    input  wire logic [W-1:0]    divisor,
    input  wire logic [TAGW-1:0] tag_in,
    output logic [W-1:0]         quotient,
    output logic [W-1:0]         remainder,
    output logic [TAGW-1:0]      tag_out
);
    logic [W-1:0]    q_reg [1:W];
    logic [W-1:0]    r_reg [1:W];
    logic [W-1:0]    d_reg [1:W];
    logic [TAGW-1:0] t_reg [1:W];

    for (genvar s = 0; s < W; s++)
    begin : g_stage
        logic [W-1:0]    q_in, r_in, d_in;
        logic [TAGW-1:0] t_in;
        logic [W:0]      trial;

        // first stage takes the raw inputs, later ones the previous registers
        if (s == 0)
        begin : g_first
            assign q_in = dividend;
            assign r_in = '0;
            assign d_in = divisor;
            assign t_in = tag_in;
        end
        else
        begin : g_next
            assign q_in = q_reg[s];
            assign r_in = r_reg[s];
            assign d_in = d_reg[s];
            assign t_in = t_reg[s];
        end

        assign trial = {r_in, q_in[W-1]} - {1'b0, d_in};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!trial[W])
                begin
                    r_reg[s+1] <= trial[W-1:0];
                    q_reg[s+1] <= {q_in[W-2:0], 1'b1};
                end
                else
                begin
                    r_reg[s+1] <= {r_in[W-2:0], q_in[W-1]};
                    q_reg[s+1] <= {q_in[W-2:0], 1'b0};
                end
                d_reg[s+1] <= d_in;
                t_reg[s+1] <= t_in;
            end
        end
    end

    assign quotient  = q_reg[W];
    assign remainder = r_reg[W];
    assign tag_out   = t_reg[W];
endmodule
`default_nettype wire

>>> bench/alu_result_checker.sv
// Checker for int32_scalar_alu: watches both stream channels, predicts each
// result from the accepted request and compares it with the returned beat.
// Depends on i32alu_pkg.
module alu_result_checker
    import i32alu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [39:0]  m_axis_tdata,
    output int           fail_count,
    output int           pending,
    output int           results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

    logic [33:0] expected_q[$];

    function automatic logic is_less(logic [31:0] a, logic [31:0] b, logic sgn);
        if (sgn)
        begin
            return (a ^ SIGN_BIT) < (b ^ SIGN_BIT);
        end
        return a < b;
    endfunction

    function automatic logic [31:0] mag(logic [31:0] v);
        return v[31] ? -v : v;
    endfunction

    // Compute {status, result_word} for one request.
    function automatic logic [33:0] alu_predict(logic [103:0] d);
        logic [4:0]  op;
        logic        sgn;
        logic [31:0] a, b, c, r, q, rem;
        status_t     st;
        op  = d[4:0];
        sgn = d[5];
        a   = d[37:6];
        b   = d[69:38];
        c   = d[101:70];
        r   = '0;
        st  = ST_OK;
        case (op)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            OP_DIV, OP_MOD:
            begin
                if (b == 0)
                    st = ST_DIV0;
                else if (!sgn)
                    r = (op == OP_DIV) ? a / b : a % b;
                else if (a == SIGN_BIT && b == 32'hFFFF_FFFF)
                    st = ST_OVF;
                else if (op == OP_DIV)
                begin
                    q = mag(a) / mag(b);
                    r = (a[31] != b[31]) ? -q : q;
                end
                else
                begin
                    rem = mag(a) % mag(b);
                    r = a[31] ? -rem : rem;
                    // Modulo follows the divisor's sign.
                    if (r != 0 && r[31] != b[31])
                        r = r + b;
                end
            end
            OP_AND: r = a & b;
            OP_OR:  r = a | b;
            OP_XOR: r = a ^ b;
            OP_SHL, OP_SHR:
            begin
                if (b >= 32)
                    st = ST_SHIFT;
                else if (op == OP_SHL)
                    r = a << b[4:0];
                else if (sgn)
                    r = $signed(a) >>> b[4:0];
                else
                    r = a >> b[4:0];
            end
            OP_MAX: r = is_less(b, a, sgn) ? a : b;
            OP_MIN: r = is_less(a, b, sgn) ? a : b;
            OP_NEG: r = -a;
            OP_ABS: r = mag(a);
            OP_NOT: r = ~a;
            OP_EQ:  r = {31'd0, a == b};
            OP_NE:  r = {31'd0, a != b};
            OP_LT:  r = {31'd0, is_less(a, b, sgn)};
            OP_LE:  r = {31'd0, !is_less(b, a, sgn)};
            OP_GT:  r = {31'd0, is_less(b, a, sgn)};
            OP_GE:  r = {31'd0, !is_less(a, b, sgn)};
            OP_SEL: r = (a != 0) ? b : c;
            default: r = '0;
        endcase
        return {st, r};
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [33:0] want;
        if (!rst_n)
        begin
            fail_count   <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_q.insert(expected_q.size(), alu_predict(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat %h", $time, m_axis_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (m_axis_tdata[31:0] !== want[31:0])
                    begin
                        $display("%0t: result_word expected %h actual %h",
                                 $time, want[31:0], m_axis_tdata[31:0]);
                        fail_count <= fail_count + 1;
                    end
                    else if (m_axis_tdata[33:32] !== want[33:32])
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want[33:32], m_axis_tdata[33:32]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

>>> bench/testbench.sv
// Top of the int32_scalar_alu bench: drives request beats under several
// idling phases and gives the verdict. Depends on i32alu_pkg,
// alu_result_checker and the int32_scalar_alu RTL.
module testbench;
    import i32alu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 35;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;  // req_type, is_signed, a, b, c, zero fill
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [39:0]  m_axis_tdata;       // result_word, status, zero fill

    int fail_count, pending, results_seen;
    int send_idle_pct = 0;   // chance in a hundred that the sender skips a cycle
    int recv_stall_pct = 0;  // chance in a hundred that the receiver holds off
    int sent = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    int32_scalar_alu DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    alu_result_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
    );

    // Receiver: stall at random per the current phase.
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Pick an operand biased toward the interesting edges.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(9))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'h1;
            5: return $urandom_range(40);
            6: return -$urandom_range(40);
            default: return $urandom;
        endcase
    endfunction

    // Send one request beat; hold it until accepted.
    task automatic send_req(logic [4:0] op, logic sgn, logic [31:0] a,
                            logic [31:0] b, logic [31:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, c, b, a, sgn, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_random(int count);
        logic [4:0]  op;
        logic [31:0] b;
        for (int i = 0; i < count; i++)
        begin
            // Mostly defined opcodes; now and then an undefined one.
            op = ($urandom_range(19) == 0) ? 5'($urandom_range(31, 22))
                                           : 5'($urandom_range(21));
            b = pick_operand();
            if ((op == OP_SHL || op == OP_SHR) && $urandom_range(3) != 0)
                b = $urandom_range(31);
            send_req(op, 1'($urandom_range(1)), pick_operand(), b, pick_operand());
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every op and each special case.
        send_req(OP_ADD, 0, 32'hFFFF_FFFF, 32'h1, 0);
        send_req(OP_SUB, 0, 32'h0, 32'h1, 0);
        send_req(OP_MUL, 1, 32'h8000_0000, 32'hFFFF_FFFF, 0);
        send_req(OP_DIV, 1, 32'h5, 32'h0, 0);
        send_req(OP_MOD, 0, 32'h5, 32'h0, 0);
        send_req(OP_DIV, 1, 32'h8000_0000, 32'hFFFF_FFFF, 0);
        send_req(OP_MOD, 1, 32'h8000_0000, 32'hFFFF_FFFF, 0);
        send_req(OP_DIV, 1, -32'd7, 32'd2, 0);
        send_req(OP_MOD, 1, -32'd7, 32'd2, 0);
        send_req(OP_MOD, 1, 32'd7, -32'd2, 0);
        send_req(OP_DIV, 0, 32'hFFFF_FFFF, 32'h3, 0);
        send_req(OP_AND, 0, 32'hF0F0_F0F0, 32'hFFFF_0000, 0);
        send_req(OP_OR,  0, 32'hF0F0_F0F0, 32'h0F0F_0000, 0);
        send_req(OP_XOR, 0, 32'hFFFF_FFFF, 32'h1234_5678, 0);
        send_req(OP_SHL, 0, 32'h1, 32'd31, 0);
        send_req(OP_SHL, 0, 32'h1, 32'd32, 0);
        send_req(OP_SHR, 1, 32'h8000_0000, 32'd31, 0);
        send_req(OP_SHR, 0, 32'h8000_0000, 32'hFFFF_FFFF, 0);
        send_req(OP_MAX, 1, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_req(OP_MIN, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_req(OP_NEG, 0, 32'h8000_0000, 0, 0);
        send_req(OP_ABS, 0, 32'h8000_0000, 0, 0);
        send_req(OP_NOT, 1, 32'h0, 0, 0);
        send_req(OP_LT, 1, 32'hFFFF_FFFF, 32'h0, 0);
        send_req(OP_SEL, 0, 32'h0, 32'hAAAA_AAAA, 32'h5555_5555);
        send_req(5'd31, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int op = OP_EQ; op <= OP_GE; op++)
            send_req(5'(op), 1, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF);

        // Random phases: none, sender idle, receiver stall, both.
        send_random(300);
        drain();  // hold off until every expected result has come
        send_idle_pct = 64;
        send_random(280);
        send_idle_pct = 0;
        recv_stall_pct = 64;
        send_random(280);
        send_idle_pct = 22;
        recv_stall_pct = 22;
        send_random(260);
        drain();
        recv_stall_pct = 0;
        repeat (LATENCY + 10) @(posedge clk);

        $display("Sent %0d requests over all ops, both signedness modes and", sent);
        $display("four idling phases; %0d results checked.", results_seen);
        if (fail_count == 0 && pending == 0)
            $display("int32_scalar_alu: match");
        else
            $display("int32_scalar_alu: mismatch");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("int32_scalar_alu: mismatch");
        $finish;
    end
endmodule
